/* hdl/kvte_pkg.sv */
// Package for the key/value table engine: field widths, status codes and defaults.
// Used by key_value_table_engine; no dependencies.
package kvte_pkg;

    localparam int DEFAULT_ENTRIES = 128;

    localparam int KEY_W    = 64;
    localparam int VALUE_W  = 64;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 7;
    localparam int COUNT_W  = 8;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t ST_INSERTED  = 3'd0;
    localparam status_t ST_UPDATED   = 3'd1;
    localparam status_t ST_DELETED   = 3'd2;
    localparam status_t ST_NOT_FOUND = 3'd3;
    localparam status_t ST_FULL      = 3'd4;

    localparam logic MODE_UPSERT = 1'b0;
    localparam logic MODE_DELETE = 1'b1;

endpackage

/* hdl/kvte_ram.sv */
// Generic single-clock RAM: one write port, one read port with registered read data.
// No dependencies.
module kvte_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/key_value_table_engine.sv */
// Key/value table engine: compact insertion-ordered table with insert/update and delete.
// Processing: scan the stored entries in order up to the match (none when empty), then a
// decision state, then on delete move each later entry down by one slot, then a result state.
// One request at a time: s_tready is high only in idle, so a new request waits until its
// result is registered; the result state waits while an earlier result is not yet taken.
// Reset clears count and control. Depends on kvte_pkg and kvte_ram; the RAMs are not cleared.
module key_value_table_engine
    import kvte_pkg::*;
#(
    parameter int ENTRIES = DEFAULT_ENTRIES
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [KEY_W+VALUE_W-1:0]    s_tdata,  // key [63:0], value [127:64]
    input  logic                        s_tuser,  // mode [0]
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [23:0]                 m_tdata   // status [2:0], slot [9:3], count [17:10]
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_RESP   = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [IW-1:0]      scan_reg, scan_next;
    logic [IW-1:0]      idx_reg, idx_next;
    logic               hit_reg, hit_next;
    logic               mode_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [VALUE_W-1:0] value_reg;
    status_t            res_status_reg, res_status_next;
    logic [IW-1:0]      res_slot_reg, res_slot_next;
    logic               m_valid_reg, m_valid_next;
    logic [23:0]        m_data_reg, m_data_next;

    logic               key_we, val_we;
    logic [IW-1:0]      waddr, raddr;
    logic [KEY_W-1:0]   key_wdata, key_rd;
    logic [VALUE_W-1:0] val_wdata, val_rd;
    logic               s_accept;

    kvte_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key_ram (
        .aclk(aclk), .we(key_we), .waddr(waddr), .wdata(key_wdata),
        .raddr(raddr), .rdata(key_rd)
    );

    kvte_ram #(.WIDTH(VALUE_W), .DEPTH(ENTRIES)) u_val_ram (
        .aclk(aclk), .we(val_we), .waddr(waddr), .wdata(val_wdata),
        .raddr(raddr), .rdata(val_rd)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // read one entry ahead of the one being compared or moved
    always_comb begin
        unique case (state_reg)
            S_SEARCH: raddr = scan_reg + IW'(1);
            S_DECIDE: raddr = idx_reg + IW'(1);
            S_SHIFT:  raddr = idx_reg + IW'(2);
            default:  raddr = '0;
        endcase
    end

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        scan_next       = scan_reg;
        idx_next        = idx_reg;
        hit_next        = hit_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        key_we          = 1'b0;
        val_we          = 1'b0;
        waddr           = idx_reg;
        key_wdata       = key_rd;
        val_wdata       = val_rd;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    scan_next = '0;
                    hit_next  = 1'b0;
                    state_next = (count_reg == '0) ? S_DECIDE : S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (key_rd == key_reg) begin
                    hit_next   = 1'b1;
                    idx_next   = scan_reg;
                    state_next = S_DECIDE;
                end else if (CW'(scan_reg) + CW'(1) == count_reg) begin
                    state_next = S_DECIDE;
                end else begin
                    scan_next = scan_reg + IW'(1);
                end
            end
            S_DECIDE: begin
                state_next    = S_RESP;
                res_slot_next = '0;
                if (mode_reg == MODE_UPSERT) begin
                    if (hit_reg) begin
                        val_we          = 1'b1;
                        waddr           = idx_reg;
                        val_wdata       = value_reg;
                        res_status_next = ST_UPDATED;
                        res_slot_next   = idx_reg;
                    end else if (count_reg < CW'(ENTRIES)) begin
                        key_we          = 1'b1;
                        val_we          = 1'b1;
                        waddr           = count_reg[IW-1:0];
                        key_wdata       = key_reg;
                        val_wdata       = value_reg;
                        count_next      = count_reg + CW'(1);
                        res_status_next = ST_INSERTED;
                        res_slot_next   = count_reg[IW-1:0];
                    end else begin
                        res_status_next = ST_FULL;
                    end
                end else begin
                    if (hit_reg) begin
                        res_status_next = ST_DELETED;
                        res_slot_next   = idx_reg;
                        if (CW'(idx_reg) + CW'(1) == count_reg) begin
                            count_next = count_reg - CW'(1);
                        end else begin
                            state_next = S_SHIFT;
                        end
                    end else begin
                        res_status_next = ST_NOT_FOUND;
                    end
                end
            end
            S_SHIFT: begin
                // move entry idx+1 down into idx
                key_we    = 1'b1;
                val_we    = 1'b1;
                waddr     = idx_reg;
                key_wdata = key_rd;
                val_wdata = val_rd;
                if (CW'(idx_reg) + CW'(2) == count_reg) begin
                    count_next = count_reg - CW'(1);
                    state_next = S_RESP;
                end else begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            S_RESP: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {6'd0, COUNT_W'(count_reg), SLOT_W'(res_slot_reg),
                                    res_status_reg};
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_reg       <= scan_next;
        idx_reg        <= idx_next;
        hit_reg        <= hit_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        m_data_reg     <= m_data_next;
        if (s_accept) begin
            mode_reg  <= s_tuser;
            key_reg   <= s_tdata[KEY_W-1:0];
            value_reg <= s_tdata[KEY_W+VALUE_W-1:KEY_W];
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(ENTRIES))
        else $error("entry count exceeds table size");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != $past(count_reg) |-> $past(state_reg) == S_DECIDE
                                       || $past(state_reg) == S_SHIFT)
        else $error("entry count changed outside decide or shift");

    a_shift_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SHIFT |-> CW'(idx_reg) + CW'(1) < count_reg)
        else $error("shift pointer past last used entry");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> state_reg == S_SEARCH || state_reg == S_DECIDE)
        else $error("accepted request did not start a search");
`endif

endmodule

/* tb/sv/tb_key_value_table_engine.sv */
// Self-checking testbench for key_value_table_engine: directed table, then random
// upsert/delete traffic checked against a behavioral copy of the table.
// Depends on kvte_pkg and the key_value_table_engine RTL.
`timescale 1ns / 100ps

module tb_key_value_table_engine;
    import kvte_pkg::*;

    localparam int ENTRIES       = DEFAULT_ENTRIES;
    localparam int RANDOM_ITEMS  = 1725;
    localparam int PHASE_ITEMS   = 300;
    localparam int CYCLE_LIMIT   = 4_000_000;
    localparam int DRAIN_CYCLES  = 2 * ENTRIES + 16;
    localparam int KEY_POOL_SIZE = 256;

    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        status_t              status;
        logic [SLOT_W-1:0]    slot;
        logic [COUNT_W-1:0]   count;
    } kv_result_t;

    typedef struct packed {
        logic         mode;
        logic [63:0]  key;
        logic [63:0]  value;
        logic         typed;
        kv_result_t   result;
    } dir_row_t;

    typedef enum int { RX_OPEN, RX_SPOTTY, RX_LONG_STALL } rx_style_t;
    typedef enum int { PH_FILL, PH_MIX, PH_DRAIN } traffic_phase_t;

    // Typed results only where they follow directly from the sequence; zero rows use the table copy.
    localparam dir_row_t DIRECTED [17] = '{
        '{MODE_DELETE, 64'h0,           64'h0,          1'b1, '{ST_NOT_FOUND, 7'd0, 8'd0}},
        '{MODE_UPSERT, 64'h0,           ALL_ONES,       1'b1, '{ST_INSERTED,  7'd0, 8'd1}},
        '{MODE_UPSERT, ALL_ONES,        64'h0,          1'b1, '{ST_INSERTED,  7'd1, 8'd2}},
        '{MODE_UPSERT, 64'h0,           64'h5,          1'b1, '{ST_UPDATED,   7'd0, 8'd2}},
        '{MODE_DELETE, ALL_ONES,        ALL_ONES,       1'b1, '{ST_DELETED,   7'd1, 8'd1}},
        '{MODE_DELETE, ALL_ONES,        64'h0,          1'b1, '{ST_NOT_FOUND, 7'd0, 8'd1}},
        '{MODE_DELETE, 64'h0,           64'h0,          1'b1, '{ST_DELETED,   7'd0, 8'd0}},
        '{MODE_UPSERT, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b0, '0},
        '{MODE_UPSERT, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0},
        '{MODE_UPSERT, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 1'b0, '0},
        '{MODE_UPSERT, 64'h8000_0000_0000_0000, 64'h1,                   1'b0, '0},
        '{MODE_DELETE, 64'h5555_5555_5555_5555, ALL_ONES,                1'b0, '0},
        '{MODE_UPSERT, 64'hAAAA_AAAA_AAAA_AAAA, 64'h0,                   1'b0, '0},
        '{MODE_DELETE, 64'h0123_4567_89AB_CDEF, 64'h0,                   1'b0, '0},
        '{MODE_DELETE, 64'hAAAA_AAAA_AAAA_AAAA, 64'h0,                   1'b0, '0},
        '{MODE_DELETE, 64'h8000_0000_0000_0000, 64'h0,                   1'b0, '0},
        '{MODE_UPSERT, 64'h1,           64'h1,          1'b0, '0}
    };

    logic                      aclk;
    logic                      aresetn;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [KEY_W+VALUE_W-1:0]  s_tdata;   // key [63:0], value [127:64]
    logic                      s_tuser;   // mode [0]
    logic                      m_tvalid;
    logic                      m_tready;
    logic [23:0]               m_tdata;   // status [2:0], slot [9:3], count [17:10]

    key_value_table_engine #(
        .ENTRIES (ENTRIES)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Behavioral copy of the table; only entries below table_used are ever read.
    logic [63:0]  table_keys   [ENTRIES];
    logic [63:0]  table_values [ENTRIES];
    int           table_used;
    int           peak_used;

    kv_result_t   pending_results [$];
    logic [63:0]  key_pool [KEY_POOL_SIZE];

    int           error_count;
    int           request_count;
    int           status_seen [5];
    int           cycle_count;
    int           burst_left;

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    function automatic kv_result_t apply_request(input logic mode, input logic [63:0] key,
                                                 input logic [63:0] value);
        kv_result_t r;
        int         hit_at;
        hit_at   = -1;
        r.slot   = '0;
        for (int i = 0; i < table_used; i++) begin
            if (hit_at < 0 && table_keys[i] == key) hit_at = i;
        end
        if (mode == MODE_UPSERT) begin
            if (hit_at >= 0) begin
                table_values[hit_at] = value;
                r.slot   = SLOT_W'(hit_at);
                r.status = ST_UPDATED;
            end else if (table_used < ENTRIES) begin
                table_keys[table_used]   = key;
                table_values[table_used] = value;
                r.slot     = SLOT_W'(table_used);
                table_used = table_used + 1;
                r.status   = ST_INSERTED;
            end else begin
                r.status = ST_FULL;
            end
        end else begin
            if (hit_at >= 0) begin
                // shift later entries down to keep the table compact
                for (int j = hit_at; j + 1 < table_used; j++) begin
                    table_keys[j]   = table_keys[j + 1];
                    table_values[j] = table_values[j + 1];
                end
                table_used = table_used - 1;
                r.slot     = SLOT_W'(hit_at);
                r.status   = ST_DELETED;
            end else begin
                r.status = ST_NOT_FOUND;
            end
        end
        r.count = COUNT_W'(table_used);
        if (table_used > peak_used) peak_used = table_used;
        return r;
    endfunction

    // Insert an idle gap (sometimes none) between bursts of requests.
    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
    endtask

    task automatic send_request(input logic mode, input logic [63:0] key,
                                input logic [63:0] value, input logic typed,
                                input kv_result_t typed_result);
        kv_result_t predicted;
        pace_sender();
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {value, key};
        do @(posedge aclk); while (!s_tready);
        predicted = apply_request(mode, key, value);
        pending_results.push_back(typed ? typed_result : predicted);
        request_count++;
    endtask

    // Receiver: ready pattern that switches at random between open, spotty and long-stall styles.
    rx_style_t rx_style;
    int        rx_style_left;
    int        rx_stall_left;

    always @(posedge aclk) begin
        if (rx_style_left == 0) begin
            rx_style      = rx_style_t'($urandom_range(0, 2));
            rx_style_left = $urandom_range(50, 400);
        end else begin
            rx_style_left--;
        end
        if (rx_stall_left != 0) begin
            rx_stall_left--;
            m_tready <= 1'b0;
        end else begin
            case (rx_style)
                RX_OPEN: begin
                    m_tready <= 1'b1;
                end
                RX_SPOTTY: begin
                    m_tready <= ($urandom_range(0, 2) != 0);
                end
                default: begin
                    m_tready <= 1'b1;
                    if ($urandom_range(0, 15) == 0) rx_stall_left = $urandom_range(1, 30);
                end
            endcase
        end
    end

    // Result checker
    always @(posedge aclk) begin
        kv_result_t want;
        kv_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.status = m_tdata[2:0];
            got.slot   = m_tdata[9:3];
            got.count  = m_tdata[17:10];
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result status %0d slot %0d count %0d",
                         $time, got.status, got.slot, got.count);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.status <= ST_FULL) status_seen[got.status]++;
                if (got.status !== want.status) begin
                    $display("%0t: status mismatch, expected %0d got %0d",
                             $time, want.status, got.status);
                    error_count++;
                end
                if (got.slot !== want.slot) begin
                    $display("%0t: slot mismatch, expected %0d got %0d",
                             $time, want.slot, got.slot);
                    error_count++;
                end
                if (got.count !== want.count) begin
                    $display("%0t: count mismatch, expected %0d got %0d",
                             $time, want.count, got.count);
                    error_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        traffic_phase_t phase;
        int             insert_pct;
        int             pick;
        logic           mode;
        logic [63:0]    key;
        logic [63:0]    value;

        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = 1'b0;
        m_tready      = 1'b0;
        table_used    = 0;
        peak_used     = 0;
        error_count   = 0;
        request_count = 0;
        cycle_count   = 0;
        burst_left    = 0;
        rx_style      = RX_OPEN;
        rx_style_left = 0;
        rx_stall_left = 0;
        foreach (status_seen[i]) status_seen[i] = 0;

        key_pool[0] = 64'h0;
        key_pool[1] = ALL_ONES;
        for (int i = 2; i < KEY_POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIRECTED[r]) begin
            send_request(DIRECTED[r].mode, DIRECTED[r].key, DIRECTED[r].value,
                         DIRECTED[r].typed, DIRECTED[r].result);
        end

        // Random traffic in repeating phases: insert-heavy fill, mixed churn, then delete-heavy drain.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            phase = traffic_phase_t'((n / PHASE_ITEMS) % 3);
            case (phase)
                PH_FILL:  insert_pct = 85;
                PH_MIX:   insert_pct = 50;
                default:  insert_pct = 15;
            endcase
            mode = ($urandom_range(0, 99) < insert_pct) ? MODE_UPSERT : MODE_DELETE;
            pick = $urandom_range(0, 99);
            if (mode == MODE_UPSERT) begin
                if (pick < 25 && table_used > 0)
                    key = table_keys[$urandom_range(0, table_used - 1)];
                else if (pick < 65)
                    key = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
                else
                    key = {$urandom, $urandom};
            end else begin
                if (pick < 70 && table_used > 0)
                    key = table_keys[$urandom_range(0, table_used - 1)];
                else if (pick < 85)
                    key = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
                else
                    key = {$urandom, $urandom};
            end
            case ($urandom_range(0, 7))
                0:       value = 64'h0;
                1:       value = ALL_ONES;
                default: value = {$urandom, $urandom};
            endcase
            send_request(mode, key, value, 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d requests, table peaked at %0d of %0d entries.",
                 request_count, peak_used, ENTRIES);
        $display("Results: inserted %0d, updated %0d, deleted %0d, not found %0d, full %0d.",
                 status_seen[ST_INSERTED], status_seen[ST_UPDATED], status_seen[ST_DELETED],
                 status_seen[ST_NOT_FOUND], status_seen[ST_FULL]);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
